// ----- hdl/b32_pkg.sv -----
package b32_pkg;

    // coding direction held in the mode register
    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam logic [5:0] QUANTUM_BAD  = 6'd32;
    localparam int         MAX_CHARS    = 3;

    // one input item
    typedef struct packed {
        logic [7:0] value_in;
        logic       last_in;
    } t_in;

    // one result item
    typedef struct packed {
        logic [7:0] value_out;
        logic       has_value;
        logic       last_out;
        logic       error;
    } t_out;

    // stream state carried from item to item
    typedef struct packed {
        logic [11:0] bit_buffer;
        logic [3:0]  bit_count;
        logic [2:0]  group_position;
        logic        padding_started;
        logic [2:0]  padding_count;
        logic        error_seen;
    } t_state;

    // everything needed to play out the results of one item
    typedef struct packed {
        t_mode                       mode;
        logic [MAX_CHARS-1:0][4:0]   quanta;
        logic [1:0]                  n_char;
        logic [3:0]                  total;
        logic [7:0]                  byte_val;
        logic                        has;
        logic                        last;
        logic                        err;
    } t_burst;

    // 5-bit group to lowercase alphabet character
    function automatic logic [7:0] b32_char(input logic [4:0] q);
        logic [7:0] c;
        if (q < 5'd26) begin
            c = 8'h61 + {3'd0, q};
        end else begin
            c = 8'h18 + {3'd0, q};
        end
        return c;
    endfunction

    // alphabet character to 5-bit group, QUANTUM_BAD for anything else
    function automatic logic [5:0] b32_quantum(input logic [7:0] c);
        logic [5:0] q;
        if (c >= 8'h61 && c <= 8'h7A) begin
            q = 6'(c - 8'h61);
        end else if (c >= 8'h32 && c <= 8'h37) begin
            q = 6'(c - 8'h18);
        end else begin
            q = QUANTUM_BAD;
        end
        return q;
    endfunction

    // pads after the last byte, by byte count mod 5
    function automatic logic [2:0] pads_by_bytes(input logic [2:0] g);
        logic [2:0] n;
        unique case (g)
            3'd1:    n = 3'd6;
            3'd2:    n = 3'd4;
            3'd3:    n = 3'd3;
            3'd4:    n = 3'd1;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // expected pads, by alphabet character count mod 8
    function automatic logic [2:0] pads_by_chars(input logic [2:0] g);
        logic [2:0] n;
        unique case (g)
            3'd2, 3'd3: n = 3'd6;
            3'd4:       n = 3'd4;
            3'd5, 3'd6: n = 3'd3;
            3'd7:       n = 3'd1;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- hdl/b32_step.sv -----
module b32_step (
    input  b32_pkg::t_mode  i_mode,
    input  b32_pkg::t_state i_state,
    input  b32_pkg::t_in    i_item,
    output b32_pkg::t_state o_state,
    output b32_pkg::t_burst o_burst
);
    import b32_pkg::*;

    // encode path
    logic [11:0] e_buf;
    logic [3:0]  e_sum;
    logic        e_two;
    logic [4:0]  e_q0;
    logic [4:0]  e_q1;
    logic [2:0]  e_rem;
    logic [11:0] e_left;
    logic [4:0]  e_part;
    logic        e_has_part;
    logic [2:0]  e_grp;
    logic [2:0]  e_pads;

    // decode path
    logic        d_pad;
    logic [5:0]  d_q;
    logic        d_ok;
    logic [11:0] d_buf;
    logic [3:0]  d_sum;
    logic        d_rdy;
    logic [2:0]  d_sh;
    logic [7:0]  d_byte;
    logic [2:0]  d_grp;
    logic [2:0]  d_pcnt;
    logic        d_err;
    logic        d_bad;

    // byte into buffer, one or two whole groups out, then the zero-filled tail
    always_comb begin
        e_buf      = {i_state.bit_buffer[3:0], i_item.value_in};
        e_sum      = {1'b0, i_state.bit_count[2:0]} + 4'd8;
        e_two      = (e_sum >= 4'd10);
        e_q0       = 5'(e_buf >> (e_sum - 4'd5));
        e_q1       = 5'(e_buf >> (e_sum - 4'd10));
        e_rem      = e_two ? 3'(e_sum - 4'd10) : 3'(e_sum - 4'd5);
        e_left     = e_buf & ((12'd1 << e_rem) - 12'd1);
        e_part     = 5'(e_left << (3'd5 - e_rem));
        e_has_part = i_item.last_in && (e_rem != 3'd0);
        e_grp      = (i_state.group_position >= 3'd4) ? 3'd0 : i_state.group_position + 3'd1;
        e_pads     = pads_by_bytes(e_grp);
    end

    // character into buffer, a byte out once eight bits have gathered
    always_comb begin
        d_pad  = (i_item.value_in == PAD_CHAR);
        d_q    = b32_quantum(i_item.value_in);
        d_ok   = !d_pad && (d_q != QUANTUM_BAD) && !i_state.padding_started;
        d_buf  = {i_state.bit_buffer[6:0], d_q[4:0]};
        d_sum  = {1'b0, i_state.bit_count[2:0]} + 4'd5;
        d_rdy  = d_ok && (d_sum >= 4'd8);
        d_sh   = 3'(d_sum - 4'd8);
        d_byte = 8'(d_buf >> d_sh);
        d_grp  = d_ok ? i_state.group_position + 3'd1 : i_state.group_position;
        d_pcnt = (d_pad && i_state.padding_count != 3'd7) ?
                 i_state.padding_count + 3'd1 : i_state.padding_count;
        d_err  = i_state.error_seen || (!d_pad && !d_ok);
        d_bad  = d_err || (d_pcnt != pads_by_chars(d_grp));
    end

    // next state and result burst for the selected direction
    always_comb begin
        o_state        = i_state;
        o_burst        = '0;
        o_burst.mode   = i_mode;
        o_burst.last   = i_item.last_in;
        unique case (i_mode)
            MODE_ENCODE: begin
                o_state.bit_buffer     = e_left;
                o_state.bit_count      = {1'b0, e_rem};
                o_state.group_position = e_grp;
                o_burst.quanta[0]      = e_q0;
                o_burst.quanta[1]      = e_two ? e_q1 : e_part;
                o_burst.quanta[2]      = e_part;
                o_burst.n_char         = 2'd1 + {1'b0, e_two} + {1'b0, e_has_part};
                o_burst.total          = {2'd0, o_burst.n_char}
                                       + (i_item.last_in ? {1'b0, e_pads} : 4'd0);
                o_burst.has            = 1'b1;
            end
            MODE_DECODE: begin
                if (d_pad) begin
                    o_state.padding_started = 1'b1;
                    o_state.padding_count   = d_pcnt;
                end else if (!d_ok) begin
                    o_state.error_seen = 1'b1;
                end else begin
                    o_state.group_position = d_grp;
                    if (d_rdy) begin
                        o_state.bit_count  = {1'b0, d_sh};
                        o_state.bit_buffer = d_buf & ((12'd1 << d_sh) - 12'd1);
                    end else begin
                        o_state.bit_count  = d_sum;
                        o_state.bit_buffer = d_buf;
                    end
                end
                o_burst.total    = (d_rdy || i_item.last_in) ? 4'd1 : 4'd0;
                o_burst.has      = d_rdy;
                o_burst.byte_val = d_rdy ? d_byte : 8'd0;
                o_burst.err      = i_item.last_in && d_bad;
            end
            default: begin
                o_burst.total = 4'd0;
            end
        endcase
        // end of stream starts the next one from a clean state
        if (i_item.last_in) begin
            o_state = '0;
        end
    end

endmodule

// ----- hdl/base32_stream_codec.sv -----
// Path: results of an item wait in the pending burst, then move one by one into the output register.
// Flow: the result sequencer sends one result per cycle while the output is not stalled;
// an item is taken only once the previous item's last result is moving out.
// Reset: synchronous, active low; selects encoding and clears stream state and valids.
module base32_stream_codec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  b32_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output b32_pkg::t_out o_out
);
    import b32_pkg::*;

    t_mode  r_mode;
    t_state r_state;
    t_state n_state;
    t_burst n_burst;
    t_burst r_pend;
    logic   r_pend_valid;
    logic [2:0] r_idx;
    logic   r_out_valid;
    t_out   r_out;
    t_out   n_out;
    logic   emit;
    logic   done;
    logic   accept;
    logic [1:0] q_sel;

    b32_step u_step (
        .i_mode  (r_mode),
        .i_state (r_state),
        .i_item  (i_in),
        .o_state (n_state),
        .o_burst (n_burst)
    );

    // handshake between the pending burst and the output register
    assign emit       = r_pend_valid && (!r_out_valid || !i_out_stall);
    assign done       = emit && (({1'b0, r_idx} + 4'd1) == r_pend.total);
    assign o_in_stall = r_pend_valid && !done;
    assign accept     = i_in_valid && !o_in_stall;

    // result at the current sequencer position
    always_comb begin
        q_sel           = (r_idx[1:0] == 2'd3) ? 2'd2 : r_idx[1:0];
        n_out           = '0;
        n_out.last_out  = r_pend.last && (({1'b0, r_idx} + 4'd1) == r_pend.total);
        n_out.error     = r_pend.err && n_out.last_out;
        unique case (r_pend.mode)
            MODE_DECODE: begin
                n_out.value_out = r_pend.byte_val;
                n_out.has_value = r_pend.has;
            end
            default: begin
                n_out.has_value = 1'b1;
                n_out.value_out = ({1'b0, r_idx} < {1'b0, r_pend.n_char}) ?
                                  b32_char(r_pend.quanta[q_sel]) : PAD_CHAR;
            end
        endcase
    end

    // mode register and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENCODE;
            r_state <= '0;
        end else if (i_cfg_we) begin
            r_mode  <= t_mode'(i_cfg_wdata);
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // pending burst and sequencer position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_idx        <= '0;
        end else if (accept) begin
            r_pend_valid <= (n_burst.total != 4'd0);
            r_idx        <= '0;
        end else if (done) begin
            r_pend_valid <= 1'b0;
        end else if (emit) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_burst;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- hdl/b32_check.sv -----
module b32_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_cfg_we,
    input logic          i_cfg_wdata,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input b32_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input b32_pkg::t_out o_out
);
    import b32_pkg::*;

    // a stalled result transfer keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an empty result only closes a stream and carries a zero value
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.has_value |-> o_out.last_out && (o_out.value_out == 8'd0))
        else $error("empty result not at end of stream");

    // the error flag rides only on the final result
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.error |-> o_out.last_out)
        else $error("error flag before end of stream");

endmodule

bind base32_stream_codec b32_check u_b32_check (.*);
